// ===== hw/rtl/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radar frame parser package
// Shared widths, codes, register defaults and the command word that travels
// from the byte parser to the result generator.
// ----------------------------------------------------------------------------
package rfp_pkg;

	// Gate count range and the command address width that covers the largest one.
	localparam int GATE_COUNT_DEF = 16;
	localparam int GATE_COUNT_MAX = 32;
	localparam int WADDR_W        = $clog2(2 * GATE_COUNT_MAX);

	// Field widths.
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 16;
	localparam int MAXLEN_W   = 13;
	localparam int STATUS_W   = 2;
	localparam int DIST_W     = 16;
	localparam int GATE_IDX_W = 4;
	localparam int ENERGY_W   = 32;
	localparam int ERR_W      = 3;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Output word packing.
	localparam int M_FIELDS_W = STATUS_W + DIST_W + GATE_IDX_W + 2 * ENERGY_W + ERR_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// Command queue depth.
	localparam int QUEUE_DEPTH = 4;

	// Register defaults.
	localparam logic [31:0]         HEADER_RST = 32'hF1F2F3F4;
	localparam logic [31:0]         FOOTER_RST = 32'hF5F6F7F8;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 13'd1024;

	// Largest status value that is passed through unchanged.
	localparam logic [BYTE_W-1:0] STATUS_MAX = 8'h02;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER = 2'd0,
		CFG_FOOTER = 2'd1,
		CFG_MAXLEN = 2'd2
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SUMMARY = 2'd0,
		KIND_GATE    = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE   = 3'd0,
		ERR_HEADER = 3'd1,
		ERR_SHORT  = 3'd2,
		ERR_LONG   = 3'd3,
		ERR_FOOTER = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FRAME = 2'd1,
		OP_ERROR = 2'd2
	} op_t;

	typedef struct packed {
		logic [31:0]         header;
		logic [31:0]         footer;
		logic [MAXLEN_W-1:0] max_len;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [WADDR_W-1:0]  addr;
		logic [ENERGY_W-1:0] data;
		logic [STATUS_W-1:0] status;
		logic [DIST_W-1:0]   distance;
		err_t                err;
	} cmd_t;

	// Byte k of a four-byte word, first byte in the low bits.
	function automatic logic [BYTE_W-1:0] word_byte(input logic [31:0] w, input logic [1:0] k);
		return w[k*8 +: 8];
	endfunction

endpackage

// ===== hw/rtl/rfp_front.sv =====
// ----------------------------------------------------------------------------
// Radar frame parser front end
// Walks the received bytes through header, length, payload and footer, and
// issues energy writes, frame results and errors as queue commands.
// ----------------------------------------------------------------------------
module rfp_front #(
	parameter int GATE_COUNT = rfp_pkg::GATE_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rfp_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rfp_pkg::BYTE_W-1:0] in_byte,
	input  logic                      q_full,
	output logic                      push,
	output rfp_pkg::cmd_t             push_cmd
);
	import rfp_pkg::*;

	localparam int ENERGY_BYTES = 8 * GATE_COUNT;
	localparam int MIN_PAYLOAD  = 3 + ENERGY_BYTES;

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_HEADER  = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_FOOTER  = 5'b10000
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [LEN_W-1:0]    pos_q, pos_d;
	logic                mis_q, mis_d;
	logic [BYTE_W-1:0]   len_lo_q, len_lo_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [BYTE_W-1:0]   status_q, status_d;
	logic [DIST_W-1:0]   dist_q, dist_d;
	logic [23:0]         part_q, part_d;

	logic                accept;
	logic                hdr_bad;
	logic                ftr_bad;
	logic [LEN_W-1:0]    full_len;
	logic [LEN_W-1:0]    pos_inc;
	logic [LEN_W-1:0]    eidx;
	logic                in_energy;

	// A byte is taken whenever the queue can hold the command it may cause.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign hdr_bad   = in_byte != word_byte(cfg.header, pos_q[1:0]);
	assign ftr_bad   = in_byte != word_byte(cfg.footer, pos_q[1:0]);
	assign full_len  = {in_byte, len_lo_q};
	assign pos_inc   = pos_q + LEN_W'(1);
	assign eidx      = pos_q - LEN_W'(3);
	assign in_energy = (pos_q >= LEN_W'(3)) && (eidx < LEN_W'(ENERGY_BYTES));

	// Parser next state and command generation.
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		mis_d    = mis_q;
		len_lo_d = len_lo_q;
		len_d    = len_q;
		status_d = status_q;
		dist_d   = dist_q;
		part_d   = part_q;
		push     = 1'b0;
		push_cmd = '0;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (in_byte == word_byte(cfg.header, 2'd0)) begin
						phase_d = PH_HEADER;
						pos_d   = LEN_W'(1);
						mis_d   = 1'b0;
					end
				end
				PH_HEADER: begin
					if (pos_q[1:0] == 2'd3) begin
						if (mis_q || hdr_bad) begin
							push         = 1'b1;
							push_cmd.op  = OP_ERROR;
							push_cmd.err = ERR_HEADER;
							phase_d      = PH_HUNT;
							pos_d        = '0;
							mis_d        = 1'b0;
						end else begin
							phase_d = PH_LENGTH;
							pos_d   = LEN_W'(4);
						end
					end else begin
						pos_d = pos_inc;
						mis_d = mis_q || hdr_bad;
					end
				end
				PH_LENGTH: begin
					if (pos_q == LEN_W'(4)) begin
						len_lo_d = in_byte;
						pos_d    = LEN_W'(5);
					end else begin
						len_d = full_len;
						if (full_len < LEN_W'(MIN_PAYLOAD)) begin
							push         = 1'b1;
							push_cmd.op  = OP_ERROR;
							push_cmd.err = ERR_SHORT;
							phase_d      = PH_HUNT;
							pos_d        = '0;
							mis_d        = 1'b0;
						end else if (full_len > LEN_W'(cfg.max_len)) begin
							push         = 1'b1;
							push_cmd.op  = OP_ERROR;
							push_cmd.err = ERR_LONG;
							phase_d      = PH_HUNT;
							pos_d        = '0;
							mis_d        = 1'b0;
						end else begin
							phase_d = PH_PAYLOAD;
							pos_d   = '0;
						end
					end
				end
				PH_PAYLOAD: begin
					if (pos_q == LEN_W'(0)) begin
						status_d = in_byte;
					end else if (pos_q == LEN_W'(1)) begin
						dist_d = {8'h00, in_byte};
					end else if (pos_q == LEN_W'(2)) begin
						dist_d = {in_byte, dist_q[7:0]};
					end else if (in_energy) begin
						// Collect four bytes, then write the whole word.
						if (eidx[1:0] == 2'd3) begin
							push          = 1'b1;
							push_cmd.op   = OP_WRITE;
							push_cmd.addr = eidx[WADDR_W+1:2];
							push_cmd.data = {in_byte, part_q};
						end else begin
							part_d[eidx[1:0]*8 +: 8] = in_byte;
						end
					end
					if (pos_inc >= len_q) begin
						phase_d = PH_FOOTER;
						pos_d   = '0;
						mis_d   = 1'b0;
					end else begin
						pos_d = pos_inc;
					end
				end
				PH_FOOTER: begin
					if (pos_q[1:0] == 2'd3) begin
						push    = 1'b1;
						phase_d = PH_HUNT;
						pos_d   = '0;
						mis_d   = 1'b0;
						if (mis_q || ftr_bad) begin
							push_cmd.op  = OP_ERROR;
							push_cmd.err = ERR_FOOTER;
						end else begin
							push_cmd.op       = OP_FRAME;
							push_cmd.status   = (status_q > STATUS_MAX) ? '0 : status_q[STATUS_W-1:0];
							push_cmd.distance = dist_q;
						end
					end else begin
						pos_d = pos_inc;
						mis_d = mis_q || ftr_bad;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					pos_d   = '0;
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			mis_q   <= 1'b0;
			len_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			mis_q   <= mis_d;
			len_q   <= len_d;
		end
	end

	// Held frame fields.
	always_ff @(posedge clk) begin
		len_lo_q <= len_lo_d;
		status_q <= status_d;
		dist_q   <= dist_d;
		part_q   <= part_d;
	end

endmodule

// ===== hw/rtl/rfp_queue.sv =====
// ----------------------------------------------------------------------------
// Radar frame parser command queue
// A short first-in first-out buffer of commands between the front end and the
// result generator.
// ----------------------------------------------------------------------------
module rfp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rfp_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output rfp_pkg::cmd_t pop_cmd
);
	import rfp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_cmd   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hw/rtl/rfp_back.sv =====
// ----------------------------------------------------------------------------
// Radar frame parser result generator
// Carries out queued commands: writes the energy memory, and emits error,
// summary and per-gate results through an output register.
// ----------------------------------------------------------------------------
module rfp_back #(
	parameter int GATE_COUNT = rfp_pkg::GATE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rfp_pkg::cmd_t                 q_cmd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rfp_pkg::KIND_W-1:0]     out_kind,
	output logic [rfp_pkg::STATUS_W-1:0]   out_status,
	output logic [rfp_pkg::DIST_W-1:0]     out_distance,
	output logic [rfp_pkg::GATE_IDX_W-1:0] out_gate,
	output logic [rfp_pkg::ENERGY_W-1:0]   out_motion,
	output logic [rfp_pkg::ENERGY_W-1:0]   out_static,
	output logic [rfp_pkg::ERR_W-1:0]      out_err,
	output logic                          out_last
);
	import rfp_pkg::*;

	localparam int WORDS = 2 * GATE_COUNT;
	localparam int AW    = $clog2(WORDS);
	localparam int GW    = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_READ = 3'b010,
		BK_LOAD = 3'b100
	} bk_state_t;

	bk_state_t           state_q, state_d;
	logic [GW-1:0]       gate_q, gate_d;

	logic [ENERGY_W-1:0] energy_mem [WORDS];
	logic [ENERGY_W-1:0] rd_mot_q;
	logic [ENERGY_W-1:0] rd_sta_q;
	logic [AW-1:0]       rd_mot_addr;
	logic [AW-1:0]       rd_sta_addr;
	logic                wr_en;
	logic                rd_en;

	logic                slot_free;
	logic                load;
	kind_t               ld_kind;
	logic [STATUS_W-1:0] ld_status;
	logic [DIST_W-1:0]   ld_distance;
	logic [GATE_IDX_W-1:0] ld_gate;
	logic [ENERGY_W-1:0] ld_motion;
	logic [ENERGY_W-1:0] ld_static;
	err_t                ld_err;
	logic                ld_last;

	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [DIST_W-1:0]   out_distance_q;
	logic [GATE_IDX_W-1:0] out_gate_q;
	logic [ENERGY_W-1:0] out_motion_q;
	logic [ENERGY_W-1:0] out_static_q;
	err_t                out_err_q;
	logic                out_last_q;

	assign slot_free   = !out_valid_q || out_ready;
	assign rd_mot_addr = AW'(gate_q);
	assign rd_sta_addr = AW'(GATE_COUNT) + AW'(gate_q);

	// Command execution and gate sequencing.
	always_comb begin
		state_d     = state_q;
		gate_d      = gate_q;
		pop         = 1'b0;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		load        = 1'b0;
		ld_kind     = KIND_SUMMARY;
		ld_status   = '0;
		ld_distance = '0;
		ld_gate     = '0;
		ld_motion   = '0;
		ld_static   = '0;
		ld_err      = ERR_NONE;
		ld_last     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					priority if (q_cmd.op == OP_WRITE) begin
						pop   = 1'b1;
						wr_en = 1'b1;
					end else if (q_cmd.op == OP_FRAME) begin
						if (slot_free) begin
							pop         = 1'b1;
							load        = 1'b1;
							ld_kind     = KIND_SUMMARY;
							ld_status   = q_cmd.status;
							ld_distance = q_cmd.distance;
							gate_d      = '0;
							state_d     = BK_READ;
						end
					end else if (q_cmd.op == OP_ERROR) begin
						if (slot_free) begin
							pop     = 1'b1;
							load    = 1'b1;
							ld_kind = KIND_ERROR;
							ld_err  = q_cmd.err;
							ld_last = 1'b1;
						end
					end else begin
						// An unused command code is dropped.
						pop = 1'b1;
					end
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_LOAD;
			end
			BK_LOAD: begin
				if (slot_free) begin
					load      = 1'b1;
					ld_kind   = KIND_GATE;
					ld_gate   = GATE_IDX_W'(gate_q);
					ld_motion = rd_mot_q;
					ld_static = rd_sta_q;
					if (gate_q == GW'(GATE_COUNT - 1)) begin
						ld_last = 1'b1;
						state_d = BK_IDLE;
					end else begin
						gate_d  = gate_q + GW'(1);
						state_d = BK_READ;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Energy memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			energy_mem[q_cmd.addr[AW-1:0]] <= q_cmd.data;
		end
		if (rd_en) begin
			rd_mot_q <= energy_mem[rd_mot_addr];
			rd_sta_q <= energy_mem[rd_sta_addr];
		end
	end

	// Control state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			gate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gate_q  <= gate_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q     <= ld_kind;
			out_status_q   <= ld_status;
			out_distance_q <= ld_distance;
			out_gate_q     <= ld_gate;
			out_motion_q   <= ld_motion;
			out_static_q   <= ld_static;
			out_err_q      <= ld_err;
			out_last_q     <= ld_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = out_kind_q;
	assign out_status   = out_status_q;
	assign out_distance = out_distance_q;
	assign out_gate     = out_gate_q;
	assign out_motion   = out_motion_q;
	assign out_static   = out_static_q;
	assign out_err      = out_err_q;
	assign out_last     = out_last_q;

endmodule

// ===== hw/rtl/radar_engineering_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Radar engineering frame parser
// Parses a received byte stream into frame summary, gate energy and error
// words. A byte that causes a result word puts its command into the queue; the
// output register loads the word from the queue head once the output is free.
// Throughput: one byte per cycle while the 4-entry command queue has room; a
// good frame's burst of 1 + GATE_COUNT words needs one energy memory read and
// then one output load per gate word, and no new command is taken meanwhile.
// Reset: parser, queue and output control clear, registers return to their
// defaults; the energy memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module radar_engineering_frame_parser #(
	parameter int GATE_COUNT = rfp_pkg::GATE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Received bytes.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
	// Result words.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [1:0] detect_status, [17:2] distance_cm, [21:18] gate_index,
	// [53:22] motion_pwr, [85:54] still_pwr, [88:86] error_code, rest zero
	output logic [rfp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic [rfp_pkg::KIND_W-1:0]      m_axis_tuser,  // [1:0] result_kind
	output logic                            m_axis_tlast   // last_result
);
	import rfp_pkg::*;

	cfg_t                  cfg_q;
	logic                  q_full;
	logic                  push;
	cmd_t                  push_cmd;
	logic                  q_valid;
	logic                  pop;
	cmd_t                  pop_cmd;
	logic [STATUS_W-1:0]   out_status;
	logic [DIST_W-1:0]     out_distance;
	logic [GATE_IDX_W-1:0] out_gate;
	logic [ENERGY_W-1:0]   out_motion;
	logic [ENERGY_W-1:0]   out_static;
	logic [ERR_W-1:0]      out_err;

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header  <= HEADER_RST;
			cfg_q.footer  <= FOOTER_RST;
			cfg_q.max_len <= MAXLEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER: cfg_q.header  <= cfg_data;
				CFG_FOOTER: cfg_q.footer  <= cfg_data;
				CFG_MAXLEN: cfg_q.max_len <= cfg_data[MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	rfp_front #(
		.GATE_COUNT(GATE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	rfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_cmd   (pop_cmd)
	);

	rfp_back #(
		.GATE_COUNT(GATE_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (pop_cmd),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (m_axis_tuser),
		.out_status   (out_status),
		.out_distance (out_distance),
		.out_gate     (out_gate),
		.out_motion   (out_motion),
		.out_static   (out_static),
		.out_err      (out_err),
		.out_last     (m_axis_tlast)
	);

	// Pack the result fields, first field in the low bits.
	assign m_axis_tdata = {{M_PAD_W{1'b0}}, out_err, out_static, out_motion, out_gate,
		out_distance, out_status};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar frame parser testbench
// Feeds byte streams of good and broken engineering frames into the parser,
// predicts every summary, gate and error word from its own copy of the frame
// state, and compares each delivered word field by field. Both stream sides
// idle at random, with one long output stall and drained pauses between
// register settings.
// ----------------------------------------------------------------------------
import rfp_pkg::*;

localparam int GATES        = GATE_COUNT_DEF;
localparam int ENERGY_BYTES = 8 * GATES;
localparam int MIN_LEN      = 3 + ENERGY_BYTES;

// One expected output word with all its fields.
typedef struct packed {
	kind_t                 kind;
	logic [STATUS_W-1:0]   status;
	logic [DIST_W-1:0]     distance;
	logic [GATE_IDX_W-1:0] gate_idx;
	logic [ENERGY_W-1:0]   motion;
	logic [ENERGY_W-1:0]   still;
	err_t                  err;
	logic                  last;
} result_word_t;

// Frame predictor and word checker.
class frame_checker;
	typedef enum {SEEK, HDR, LEN, BODY, TAIL} parse_at_t;

	logic [31:0]         header_word;
	logic [31:0]         footer_word;
	logic [MAXLEN_W-1:0] max_len;

	parse_at_t   parse_at;
	int          pos;
	logic [15:0] plen;
	logic [7:0]  status;
	logic [15:0] distance;
	logic [7:0]  energy [ENERGY_BYTES];
	bit          bad;

	result_word_t result_words_due [$];
	int errors;
	int n_bytes;
	int n_checked;
	int n_results;
	int n_frames;
	int n_err [5];

	function new();
		header_word = HEADER_RST;
		footer_word = FOOTER_RST;
		max_len     = MAXLEN_RST;
		parse_at    = SEEK;
		pos         = 0;
		plen        = '0;
		status      = '0;
		distance    = '0;
		bad         = 0;
		errors      = 0;
		n_bytes     = 0;
		n_checked   = 0;
		n_results   = 0;
		n_frames    = 0;
		foreach (n_err[i]) n_err[i] = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [31:0] val);
		case (idx)
			CFG_HEADER: header_word = val;
			CFG_FOOTER: footer_word = val;
			CFG_MAXLEN: max_len = val[MAXLEN_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return result_words_due.size();
	endfunction

	function void push_result(result_word_t r);
		result_words_due.push_back(r);
		n_results++;
	endfunction

	// A bad frame gives a single error word and sends the parser back to hunting.
	function void flag_error(err_t code);
		result_word_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.err  = code;
		r.last = 1'b1;
		push_result(r);
		n_err[code]++;
		parse_at = SEEK;
		pos      = 0;
		bad      = 0;
	endfunction

	function logic [31:0] le_word(int base);
		return {energy[base+3], energy[base+2], energy[base+1], energy[base]};
	endfunction

	// A good frame gives the summary word and then one word per gate.
	function void emit_frame();
		result_word_t r;
		r = '0;
		r.kind     = KIND_SUMMARY;
		r.status   = (status > STATUS_MAX) ? '0 : status[STATUS_W-1:0];
		r.distance = distance;
		push_result(r);
		for (int g = 0; g < GATES; g++) begin
			r = '0;
			r.kind     = KIND_GATE;
			r.gate_idx = g[GATE_IDX_W-1:0];
			r.motion   = le_word(4 * g);
			r.still    = le_word(4 * (GATES + g));
			r.last     = (g == GATES - 1);
			push_result(r);
		end
		n_frames++;
	endfunction

	// Advance the frame state by one accepted byte.
	function void note_byte(logic [7:0] b);
		n_bytes++;
		case (parse_at)
			SEEK: begin
				if (b == header_word[7:0]) begin
					parse_at = HDR;
					pos      = 1;
					bad      = 0;
				end
			end
			HDR: begin
				if (b != header_word[pos*8 +: 8]) bad = 1;
				pos++;
				if (pos == 4) begin
					if (bad) begin
						flag_error(ERR_HEADER);
					end else begin
						parse_at = LEN;
						plen     = '0;
					end
				end
			end
			LEN: begin
				if (pos == 4) begin
					plen = {8'h00, b};
					pos  = 5;
				end else begin
					plen[15:8] = b;
					if (plen < MIN_LEN) begin
						flag_error(ERR_SHORT);
					end else if (plen > max_len) begin
						flag_error(ERR_LONG);
					end else begin
						parse_at = BODY;
						pos      = 0;
					end
				end
			end
			BODY: begin
				if (pos == 0) status = b;
				else if (pos == 1) distance[7:0] = b;
				else if (pos == 2) distance[15:8] = b;
				else if (pos - 3 < ENERGY_BYTES) energy[pos-3] = b;
				pos++;
				if (pos >= int'(plen)) begin
					parse_at = TAIL;
					pos      = 0;
					bad      = 0;
				end
			end
			TAIL: begin
				if (b != footer_word[pos*8 +: 8]) bad = 1;
				pos++;
				if (pos == 4) begin
					if (bad) begin
						flag_error(ERR_FOOTER);
					end else begin
						emit_frame();
						parse_at = SEEK;
						pos      = 0;
						bad      = 0;
					end
				end
			end
			default: begin
				parse_at = SEEK;
				pos      = 0;
			end
		endcase
	endfunction

	function void compare(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			errors++;
			if (errors < 40)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
		end
	endfunction

	// Compare one delivered word against the oldest expected word.
	function void check_word(logic [M_TDATA_W-1:0] d, logic [KIND_W-1:0] u, logic l);
		result_word_t e;
		if (result_words_due.size() == 0) begin
			errors++;
			if (errors < 40)
				$display("%0t: unexpected word, expected none, actual kind %0h data %0h",
					$time, u, d);
			return;
		end
		e = result_words_due.pop_front();
		n_checked++;
		compare("result_kind", 32'(e.kind), 32'(u));
		compare("detect_status", 32'(e.status), 32'(d[1:0]));
		compare("distance_cm", 32'(e.distance), 32'(d[17:2]));
		compare("gate_index", 32'(e.gate_idx), 32'(d[21:18]));
		compare("motion_pwr", e.motion, d[53:22]);
		compare("still_pwr", e.still, d[85:54]);
		compare("error_code", 32'(e.err), 32'(d[88:86]));
		compare("last_result", 32'(e.last), 32'(l));
	endfunction
endclass

module tb_top;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_COUNT} fill_t;

	localparam int DRAIN_CYCLES = 2 * GATES + 16;
	localparam int HOLD_CYCLES  = 400;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic [KIND_W-1:0]      m_axis_tuser;
	logic                   m_axis_tlast;

	frame_checker sb = new();

	// Stimulus state shared by the driving tasks.
	logic [7:0]          frame_buf [$];
	logic [31:0]         cur_header = HEADER_RST;
	logic [31:0]         cur_footer = FOOTER_RST;
	int                  burst_left = 0;
	bit                  no_gaps = 0;

	// Receiver stall state.
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	int mode = 0;
	int mode_cnt = 0;

	radar_engineering_frame_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit well above the slowest correct run.
	initial begin
		#8000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Output ready: one long hold-off on request, otherwise a changing stall pattern.
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt = HOLD_CYCLES;
			hold_done = 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_cnt == 0) begin
				mode = $urandom_range(0, 3);
				mode_cnt = $urandom_range(20, 200);
			end else begin
				mode_cnt--;
			end
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (mode_cnt[1:0] != 2'd0);
			endcase
		end
	end

	// Check delivered words before noting bytes accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_byte(s_axis_tdata);
		end
	end

	// Offer one byte and wait until it is taken; gaps fall between bursts.
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			if (!no_gaps) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= 8'($urandom);
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_buf();
		while (frame_buf.size() != 0) send_byte(frame_buf.pop_front());
	endtask

	// Stop offering and wait until every expected word has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		case (idx)
			CFG_HEADER: cur_header = val;
			CFG_FOOTER: cur_footer = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++) frame_buf.push_back(w[8*k +: 8]);
	endtask

	// Header with optional corruption, followed by the two length bytes.
	task automatic push_head(input logic [31:0] hdr_xor, input logic [15:0] len);
		push_word(cur_header ^ hdr_xor);
		frame_buf.push_back(len[7:0]);
		frame_buf.push_back(len[15:8]);
	endtask

	// Whole frame; a nonzero footer mask corrupts the footer.
	task automatic push_frame(input int len, input logic [7:0] status, input logic [15:0] dist_cm,
			input fill_t fill, input logic [31:0] ftr_xor);
		push_head('0, len[15:0]);
		frame_buf.push_back(status);
		frame_buf.push_back(dist_cm[7:0]);
		frame_buf.push_back(dist_cm[15:8]);
		for (int i = 3; i < len; i++) begin
			case (fill)
				FILL_ZERO: frame_buf.push_back(8'h00);
				FILL_ONES: frame_buf.push_back(8'hFF);
				FILL_COUNT: frame_buf.push_back(i[7:0]);
				default: frame_buf.push_back(8'($urandom));
			endcase
		end
		push_word(cur_footer ^ ftr_xor);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: noise, a good frame with extra payload, and each
		// header and length error.
		push_word(32'hAA55FF00);
		push_frame(MIN_LEN + 4, 8'h03, 16'hFFFF, FILL_COUNT, '0);
		push_head(32'h0000FF00, 16'd200);
		push_head(32'h00FF0000, 16'd200);
		push_head(32'hFF000000, 16'd200);
		push_head('0, 16'(MIN_LEN - 1));
		push_head('0, 16'd1025);
		send_buf();
		drain();

		// A maximum below the frame minimum rejects every length.
		write_reg(CFG_MAXLEN, 100);
		push_head('0, 16'(MIN_LEN));
		send_buf();
		drain();

		// Tightest maximum with new header and footer words. The output holds off
		// for a long stretch while two frames come back to back, so the command
		// queue fills up and the input stalls.
		write_reg(CFG_MAXLEN, MIN_LEN);
		write_reg(CFG_HEADER, $urandom);
		write_reg(CFG_FOOTER, 32'hFFFFFFFF);
		hold_req = 1;
		no_gaps = 1;
		push_frame(MIN_LEN, 8'h02, 16'h0000, FILL_ONES, '0);
		push_frame(MIN_LEN, 8'h01, 16'h1234, FILL_RANDOM, 32'h00008000);
		send_buf();
		no_gaps = 0;
		push_head('0, 16'(MIN_LEN + 1));
		send_buf();
		drain();

		$display("Run covered %0d bytes and %0d good frames; %0d of %0d result words checked.",
			sb.n_bytes, sb.n_frames, sb.n_checked, sb.n_results);
		$display("Frame errors: header %0d, short length %0d, long length %0d, footer %0d.",
			sb.n_err[ERR_HEADER], sb.n_err[ERR_SHORT], sb.n_err[ERR_LONG], sb.n_err[ERR_FOOTER]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_front.sv
hw/rtl/rfp_queue.sv
hw/rtl/rfp_back.sv
hw/rtl/radar_engineering_frame_parser.sv
test/tb_top.sv
